// ===== rtl/core/lobh_pkg.sv =====
package lobh_pkg;

    localparam int unsigned IDX_W     = 5;
    localparam int unsigned NUM_POS   = 32;
    localparam int unsigned VAL_W     = 32;
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned ACT_W     = 6;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DROP    = 2'd1;
    localparam logic [1:0] ST_BAD_IDX = 2'd2;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_ACTIVE = 1'b1;

    typedef struct packed {
        logic             found;
        logic [1:0]       status;
        logic [IDX_W-1:0] used;
    } lobh_class_t;

    function automatic logic [VAL_W-1:0] upper_bound(input logic [IDX_W-1:0] idx,
                                                     input logic exp_mode);
        logic [VAL_W-1:0] res;
        if (exp_mode)
        begin
            res = VAL_W'(1) << idx;
        end
        else
        begin
            res = VAL_W'(idx) + VAL_W'(1);
        end
        return res;
    endfunction

    function automatic logic [VAL_W-1:0] lower_bound(input logic [IDX_W-1:0] idx,
                                                     input logic exp_mode);
        logic [VAL_W-1:0] res;
        if (idx == '0)
        begin
            res = '0;
        end
        else
        begin
            res = upper_bound(idx - IDX_W'(1), exp_mode) + VAL_W'(1);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/lobh_classify.sv =====
module lobh_classify
    import lobh_pkg::*;
(
    input  logic             action,
    input  logic [VAL_W-1:0] sample_value,
    input  logic [IDX_W-1:0] read_index,
    input  logic             exp_mode,
    input  logic [ACT_W-1:0] n_active,
    output lobh_class_t      cls
);

    logic [NUM_POS-1:0] le;
    logic [NUM_POS-1:0] active_mask;
    logic [NUM_POS-1:0] below;
    logic [ACT_W-1:0]   below_cnt;
    logic               add_found;

    // Bounds rise with the index, so the first fitting bucket is the count of
    // active bounds that lie below the value.
    always_comb
    begin
        for (int i = 0; i < NUM_POS; i++)
        begin
            le[i]          = sample_value <= upper_bound(IDX_W'(i), exp_mode);
            active_mask[i] = ACT_W'(i) < n_active;
        end
        below     = ~le & active_mask;
        below_cnt = ACT_W'($countones(below));
        add_found = |(le & active_mask);
    end

    always_comb
    begin
        cls = '0;
        if (action == ACT_ADD)
        begin
            if (add_found)
            begin
                cls.found  = 1'b1;
                cls.status = ST_OK;
                cls.used   = below_cnt[IDX_W-1:0];
            end
            else
            begin
                cls.status = ST_DROP;
            end
        end
        else
        begin
            if (ACT_W'(read_index) < n_active)
            begin
                cls.found  = 1'b1;
                cls.status = ST_OK;
                cls.used   = read_index;
            end
            else
            begin
                cls.status = ST_BAD_IDX;
            end
        end
    end

endmodule

// ===== rtl/core/linear_or_log_bucket_histogram.sv =====
// Channel   Direction  Payload
// s_axis    in         tuser: action; tdata: sample_value, add_amount, read_index
// m_axis    out        tuser: status; tdata: bucket_used, count, low, high
// apb       in/out     reg 0 exponential_mode (addr 0), reg 1 active_buckets (addr 4)
//
// One item per cycle while the result is not stalled: an accepted request waits
// in the input register, where the bucket encode and counter read-add-write
// finish, then moves to the result register, which drives m_tvalid.
// rst_n clears the counters and both valid flags at once; the data registers are not reset.
// A stalled result holds the input register; s_tready stays high while either
// stage can move.
module linear_or_log_bucket_histogram
    import lobh_pkg::*;
#(
    parameter int unsigned MAX_BUCKETS = 32
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] sample_value, [63:32] add_amount, [68:64] read_index, [71:69] zero
    input  logic [71:0]  s_tdata,
    // [0] action
    input  logic         s_tuser,

    output logic         m_tvalid,
    input  logic         m_tready,
    // [4:0] bucket_used, [36:5] bucket_count_out, [68:37] bucket_low,
    // [100:69] bucket_high, [103:101] zero
    output logic [103:0] m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int unsigned CIDX_W = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;

    logic             exp_mode_reg;
    logic [ACT_W-1:0] active_reg;

    logic             in_valid_reg;
    logic             in_action_reg;
    logic [VAL_W-1:0] in_value_reg;
    logic [CNT_W-1:0] in_amount_reg;
    logic [IDX_W-1:0] in_ridx_reg;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [IDX_W-1:0] out_used_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic [VAL_W-1:0] out_low_reg;
    logic [VAL_W-1:0] out_high_reg;

    logic [CNT_W-1:0] counters_reg [MAX_BUCKETS];

    logic             cfg_wr;
    logic             advance;
    logic             in_fire;
    logic             fire;
    logic [ACT_W-1:0] n_active;
    lobh_class_t      cls;
    logic [CNT_W-1:0] cur_count;
    logic [CNT_W-1:0] sum_count;
    logic             cnt_we;

    logic [1:0]       out_status_next;
    logic [IDX_W-1:0] out_used_next;
    logic [CNT_W-1:0] out_count_next;
    logic [VAL_W-1:0] out_low_next;
    logic [VAL_W-1:0] out_high_next;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_MODE:   prdata = {31'd0, exp_mode_reg};
            REG_ACTIVE: prdata = {{(32 - ACT_W){1'b0}}, active_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_mode_reg <= 1'b0;
            active_reg   <= ACT_W'(32);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_MODE:   exp_mode_reg <= pwdata[0];
                REG_ACTIVE: active_reg   <= pwdata[ACT_W-1:0];
                default:    ;
            endcase
        end
    end

    // clamp the active count to one..MAX_BUCKETS
    always_comb
    begin
        if (active_reg == '0)
        begin
            n_active = ACT_W'(1);
        end
        else if (active_reg > ACT_W'(MAX_BUCKETS))
        begin
            n_active = ACT_W'(MAX_BUCKETS);
        end
        else
        begin
            n_active = active_reg;
        end
    end

    // handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign in_fire  = s_tvalid && s_tready;
    assign fire     = in_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_action_reg <= s_tuser;
            in_value_reg  <= s_tdata[31:0];
            in_amount_reg <= s_tdata[63:32];
            in_ridx_reg   <= s_tdata[68:64];
        end
    end

    lobh_classify u_classify (
        .action       (in_action_reg),
        .sample_value (in_value_reg),
        .read_index   (in_ridx_reg),
        .exp_mode     (exp_mode_reg),
        .n_active     (n_active),
        .cls          (cls)
    );

    // read-add-write of the chosen counter
    assign cur_count = counters_reg[cls.used[CIDX_W-1:0]];
    assign sum_count = cur_count + in_amount_reg;
    assign cnt_we    = fire && cls.found && (in_action_reg == ACT_ADD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BUCKETS; i++)
            begin
                counters_reg[i] <= '0;
            end
        end
        else if (cnt_we)
        begin
            counters_reg[cls.used[CIDX_W-1:0]] <= sum_count;
        end
    end

    always_comb
    begin
        out_status_next = cls.status;
        out_used_next   = '0;
        out_count_next  = '0;
        out_low_next    = '0;
        out_high_next   = '0;
        if (cls.found)
        begin
            out_used_next  = cls.used;
            out_count_next = (in_action_reg == ACT_ADD) ? sum_count : cur_count;
            out_low_next   = lower_bound(cls.used, exp_mode_reg);
            out_high_next  = upper_bound(cls.used, exp_mode_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_status_reg <= out_status_next;
            out_used_reg   <= out_used_next;
            out_count_reg  <= out_count_next;
            out_low_reg    <= out_low_next;
            out_high_reg   <= out_high_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'd0, out_high_reg, out_low_reg, out_count_reg, out_used_reg};

`ifndef SYNTHESIS
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("failed request carries nonzero payload");

    a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_OK) |-> (m_tdata[68:37] <= m_tdata[100:69]))
        else $error("bucket low bound above high bound");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && m_tvalid && !m_tready) |=>
            (in_valid_reg && $stable(in_value_reg) && $stable(in_action_reg)))
        else $error("input stage changed under a stalled result");

    a_write_only_add: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_we |-> (cls.status == ST_OK && in_valid_reg))
        else $error("counter written without a valid add");
`endif

endmodule

// ===== tb/sv/tb_linear_or_log_bucket_histogram.sv =====
module tb_linear_or_log_bucket_histogram
    import lobh_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_ADDR   = {REG_MODE, 2'b00};
    localparam logic [2:0] ACTIVE_ADDR = {REG_ACTIVE, 2'b00};

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] bucket;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] low;
        logic [VAL_W-1:0] high;
    } bucket_reply_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // predicted histogram state and register shadows
    logic [CNT_W-1:0] tally [NUM_POS];
    logic             exp_shadow;
    logic [ACT_W-1:0] active_shadow;

    bucket_reply_t predicted_replies[$];
    int            fail_count;
    int            send_idle_pct;
    int            recv_idle_pct;

    linear_or_log_bucket_histogram dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned buckets_in_use();
        int unsigned n;
        n = active_shadow;
        if (n == 0)
        begin
            n = 1;
        end
        if (n > NUM_POS)
        begin
            n = NUM_POS;
        end
        return n;
    endfunction

    function automatic logic [VAL_W-1:0] bucket_top(input logic [IDX_W-1:0] slot);
        logic [VAL_W-1:0] top;
        if (exp_shadow)
        begin
            top = 32'h1 << slot;
        end
        else
        begin
            top = {27'd0, slot} + 32'd1;
        end
        return top;
    endfunction

    function automatic logic [VAL_W-1:0] bucket_floor(input logic [IDX_W-1:0] slot);
        logic [VAL_W-1:0] floor_val;
        if (slot == 5'd0)
        begin
            floor_val = '0;
        end
        else
        begin
            floor_val = bucket_top(slot - 5'd1) + 32'd1;
        end
        return floor_val;
    endfunction

    function automatic bucket_reply_t predict_request(input logic action,
                                                      input logic [VAL_W-1:0] value,
                                                      input logic [CNT_W-1:0] amount,
                                                      input logic [IDX_W-1:0] index);
        bucket_reply_t r;
        int unsigned   n;
        logic          hit;
        logic [4:0]    slot;
        r    = '0;
        n    = buckets_in_use();
        hit  = 1'b0;
        slot = '0;
        if (action == ACT_ADD)
        begin
            // first active bucket whose upper bound covers the value
            for (int i = 0; i < n; i++)
            begin
                if (!hit && value <= bucket_top(5'(i)))
                begin
                    hit  = 1'b1;
                    slot = 5'(i);
                end
            end
            if (hit)
            begin
                tally[slot] = tally[slot] + amount;
            end
            else
            begin
                r.status = ST_DROP;
            end
        end
        else
        begin
            if (index < n)
            begin
                hit  = 1'b1;
                slot = index;
            end
            else
            begin
                r.status = ST_BAD_IDX;
            end
        end
        if (hit)
        begin
            r.status = ST_OK;
            r.bucket = slot;
            r.count  = tally[slot];
            r.low    = bucket_floor(slot);
            r.high   = bucket_top(slot);
        end
        return r;
    endfunction

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        bucket_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_replies.size() == 0)
            begin
                $error("result with no request outstanding: status %0d tdata %h",
                       m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                want = predicted_replies.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    fail_count++;
                end
                if (m_tdata[4:0] !== want.bucket)
                begin
                    $error("bucket_used: expected %0d, got %0d", want.bucket, m_tdata[4:0]);
                    fail_count++;
                end
                if (m_tdata[36:5] !== want.count)
                begin
                    $error("bucket_count_out: expected %h, got %h",
                           want.count, m_tdata[36:5]);
                    fail_count++;
                end
                if (m_tdata[68:37] !== want.low)
                begin
                    $error("bucket_low: expected %h, got %h", want.low, m_tdata[68:37]);
                    fail_count++;
                end
                if (m_tdata[100:69] !== want.high)
                begin
                    $error("bucket_high: expected %h, got %h", want.high, m_tdata[100:69]);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(input logic action, input logic [VAL_W-1:0] value,
                                input logic [CNT_W-1:0] amount,
                                input logic [IDX_W-1:0] index);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {3'b000, index, amount, value};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted_replies.push_back(predict_request(action, value, amount, index));
    endtask

    // drop valid and hold until every outstanding request has its result
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (predicted_replies.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] wdata, input logic [31:0] rexpect);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        if (!write && prdata !== rexpect)
        begin
            $error("prdata at %0d: expected %h, got %h", addr, rexpect, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_histogram_config(input logic mode, input logic [ACT_W-1:0] active);
        wait_drained();
        apb_access(1'b1, MODE_ADDR, {31'd0, mode}, '0);
        exp_shadow = mode;
        apb_access(1'b1, ACTIVE_ADDR, {26'd0, active}, '0);
        active_shadow = active;
        apb_access(1'b0, MODE_ADDR, '0, {31'd0, mode});
        apb_access(1'b0, ACTIVE_ADDR, '0, {26'd0, active});
    endtask

    task automatic test_linear_edges();
        // counters start at zero; bucket 0 takes 0 and 1, and wraps
        send_request(ACT_READ, '0, '0, 5'd0);
        send_request(ACT_ADD, 32'd0, 32'hFFFF_FFFF, 5'd31);
        send_request(ACT_ADD, 32'd1, 32'd1, 5'd0);
        send_request(ACT_ADD, 32'd32, 32'h8000_0000, 5'd0);
        send_request(ACT_ADD, 32'd33, 32'd7, 5'd0);
        send_request(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_request(ACT_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_request(ACT_READ, '0, '0, 5'd0);
    endtask

    task automatic test_active_limits();
        // zero active buckets behaves as one
        set_histogram_config(1'b0, 6'd0);
        send_request(ACT_ADD, 32'd2, 32'd5, 5'd0);
        send_request(ACT_ADD, 32'd1, 32'd5, 5'd0);
        send_request(ACT_READ, '0, '0, 5'd1);
        send_request(ACT_READ, '0, '0, 5'd0);
        // counts above the maximum saturate
        set_histogram_config(1'b0, 6'd63);
        send_request(ACT_ADD, 32'd32, 32'd3, 5'd0);
        send_request(ACT_READ, '0, '0, 5'd31);
    endtask

    task automatic test_exponential_edges();
        // counters survive the mode change; only the bounds move
        set_histogram_config(1'b1, 6'd32);
        send_request(ACT_ADD, 32'h8000_0000, 32'd9, 5'd0);
        send_request(ACT_ADD, 32'h8000_0001, 32'd9, 5'd0);
        send_request(ACT_ADD, 32'd2, 32'd1, 5'd0);
        send_request(ACT_ADD, 32'd3, 32'd1, 5'd0);
        send_request(ACT_ADD, 32'd0, 32'd1, 5'd0);
        send_request(ACT_READ, '0, '0, 5'd31);
        send_request(ACT_READ, '0, '0, 5'd5);
    endtask

    task automatic send_random_request();
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] amount;
        int unsigned      n;
        n      = buckets_in_use();
        amount = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 255));
        if (!exp_shadow)
        begin
            case ($urandom_range(0, 9))
                0:       value = $urandom;
                1:       value = 32'(n + $urandom_range(0, 3));
                default: value = 32'($urandom_range(0, n));
            endcase
        end
        else
        begin
            case ($urandom_range(0, 9))
                0:       value = $urandom;
                1:       value = (32'h1 << $urandom_range(0, 31)) + 32'($urandom_range(0, 1));
                default: value = $urandom >> $urandom_range(0, 32);
            endcase
        end
        if ($urandom_range(0, 9) < 7)
        begin
            send_request(ACT_ADD, value, amount, 5'($urandom_range(0, 31)));
        end
        else
        begin
            send_request(ACT_READ, value, amount, 5'($urandom_range(0, 31)));
        end
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct);
        logic [ACT_W-1:0] active;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int s = 0; s < 4; s++)
        begin
            case ($urandom_range(0, 5))
                0:       active = 6'd0;
                1:       active = 6'd1;
                2:       active = 6'd32;
                3:       active = 6'($urandom_range(33, 63));
                default: active = 6'($urandom_range(1, 32));
            endcase
            set_histogram_config(1'($urandom_range(0, 1)), active);
            for (int k = 0; k < 125; k++)
            begin
                send_random_request();
            end
        end
    endtask

    task automatic test_drain_pause();
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 8; k++)
            begin
                send_random_request();
            end
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        fail_count    = 0;
        send_idle_pct = 14;
        recv_idle_pct = 60;
        exp_shadow    = 1'b0;
        active_shadow = 6'd32;
        for (int i = 0; i < NUM_POS; i++)
        begin
            tally[i] = '0;
        end
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_linear_edges();
        test_active_limits();
        test_exponential_edges();
        test_random_traffic(14, 60);
        test_drain_pause();
        test_random_traffic(60, 14);
        test_random_traffic(0, 0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
